FILE: sv/cpq_pkg.sv
// class priority request queue: shared constants, codes and cell interface types
// no dependencies
`default_nettype none

package cpq_pkg;

   localparam int DEPTH    = 16;
   localparam int TAG_BITS = 16;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int OCC_W    = 5;
   localparam int CAP_W    = 5;
   localparam int MODE_W   = 2;
   localparam int CSR_AW   = 8;
   localparam int CSR_DW   = 8;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [MODE_W-1:0] MODE_FIFO  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_IMAGE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd2;

   localparam logic [CSR_AW-1:0] REG_SCHED_MODE = 8'd0;
   localparam logic [CSR_AW-1:0] REG_CAPACITY   = 8'd1;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic                is_image;
   } entry_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic             enq;
      logic             deq;
      logic             use_pref;
      logic             want;
      logic             any_pref;
      logic [CNT_W-1:0] count;
   } ctl_type;

endpackage

`default_nettype wire

FILE: sv/class_priority_request_queue_top.sv
// class priority request queue top: control, result register and row of cells
// uses cpq_pkg and cpq_cell
// result: registered, on the rsp_ ports in the cycle after the request is accepted
// throughput: one transaction per cycle while no stalled result holds req_stall high
// reset: synchronous, clears count, mode (oldest first) and capacity (16)
`default_nettype none

module class_priority_request_queue_top (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_op,
   input  wire [15:0]                        req_tag,
   input  wire                               req_is_image,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [15:0]                       rsp_out_tag,
   output logic                              rsp_out_is_image,
   output logic [4:0]                        rsp_occupancy,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [cpq_pkg::CSR_AW-1:0]         csr_index,
   input  wire [cpq_pkg::CSR_DW-1:0]         csr_wdata
);

   localparam int D = cpq_pkg::DEPTH;

   logic [cpq_pkg::MODE_W-1:0] mode_ff;
   logic [cpq_pkg::CAP_W-1:0]  cap_ff;
   logic [cpq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 status_ff, status_in;
   cpq_pkg::entry_type         out_ff, out_in;

   cpq_pkg::ctl_type   ctl;
   cpq_pkg::entry_type enq_entry;
   cpq_pkg::entry_type cell_entry [D];
   logic [D:0]         found;
   logic [D-1:0]       picked;
   logic               accept;
   logic               full;
   cpq_pkg::entry_type pick_entry;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign enq_entry.tag      = req_tag[cpq_pkg::TAG_BITS-1:0];
   assign enq_entry.is_image = req_is_image;
   assign found[0]           = 1'b0;

   always_comb begin
      full = (32'(count_ff) >= 32'(cap_ff)) || (32'(count_ff) >= 32'(D));
      ctl.count    = count_ff;
      ctl.enq      = accept && (req_op == cpq_pkg::OP_ENQ) && !full;
      ctl.deq      = accept && (req_op == cpq_pkg::OP_DEQ) && (count_ff != '0);
      ctl.use_pref = (mode_ff == cpq_pkg::MODE_IMAGE) || (mode_ff == cpq_pkg::MODE_TEXT);
      ctl.want     = (mode_ff == cpq_pkg::MODE_IMAGE);
      ctl.any_pref = found[D];
   end

   for (genvar i = 0; i < D; i++) begin : g_cell
      cpq_pkg::entry_type next_entry;
      if (i == D - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end
      cpq_cell u_cell (
         .clock      (clock),
         .cell_index (cpq_pkg::IDX_W'(i)),
         .ctl        (ctl),
         .enq_entry  (enq_entry),
         .next_entry (next_entry),
         .found_in   (found[i]),
         .found_out  (found[i+1]),
         .picked     (picked[i]),
         .entry      (cell_entry[i])
      );
   end

   always_comb begin
      pick_entry = '0;
      for (int i = 0; i < D; i++) begin
         if (picked[i]) begin
            pick_entry = pick_entry | cell_entry[i];
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_in       = '0;
         if (req_op == cpq_pkg::OP_ENQ) begin
            if (full) begin
               status_in = cpq_pkg::ST_FULL;
            end else begin
               status_in = cpq_pkg::ST_OK;
               count_in  = count_ff + cpq_pkg::CNT_W'(1);
            end
         end else if (count_ff == '0) begin
            status_in = cpq_pkg::ST_EMPTY;
         end else begin
            status_in = cpq_pkg::ST_OK;
            out_in    = pick_entry;
            count_in  = count_ff - cpq_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= cpq_pkg::MODE_FIFO;
         cap_ff       <= cpq_pkg::CAP_RESET;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == cpq_pkg::REG_SCHED_MODE) begin
               mode_ff <= csr_wdata[cpq_pkg::MODE_W-1:0];
            end else if (csr_index == cpq_pkg::REG_CAPACITY) begin
               cap_ff <= csr_wdata[cpq_pkg::CAP_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_tag      = 16'(out_ff.tag);
   assign rsp_out_is_image = out_ff.is_image;
   assign rsp_occupancy    = cpq_pkg::OCC_W'(count_ff);

endmodule

`default_nettype wire

FILE: sv/cpq_cell.sv
// one queue slot: holds an entry, detects a preferred-class match and
// collapses toward the head on removal; uses cpq_pkg
`default_nettype none

module cpq_cell (
   input  wire                         clock,
   input  wire [cpq_pkg::IDX_W-1:0]    cell_index,
   input  cpq_pkg::ctl_type            ctl,
   input  cpq_pkg::entry_type          enq_entry,
   input  cpq_pkg::entry_type          next_entry,
   input  wire                         found_in,
   output logic                        found_out,
   output logic                        picked,
   output cpq_pkg::entry_type          entry
);

   cpq_pkg::entry_type entry_ff;
   cpq_pkg::entry_type entry_in;
   logic               occupied;
   logic               match;
   logic               at_or_after;
   logic               pref_path;

   always_comb begin
      occupied    = cpq_pkg::CNT_W'(cell_index) < ctl.count;
      match       = occupied && (entry_ff.is_image == ctl.want);
      found_out   = found_in | match;
      pref_path   = ctl.use_pref & ctl.any_pref;
      picked      = pref_path ? (match & ~found_in) : (cell_index == '0);
      at_or_after = pref_path ? found_out : 1'b1;
      entry_in    = entry_ff;
      if (ctl.enq && (cpq_pkg::CNT_W'(cell_index) == ctl.count)) begin
         entry_in = enq_entry;
      end else if (ctl.deq && at_or_after) begin
         entry_in = next_entry;
      end
      entry = entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

FILE: sv/cpq_checker.sv
// port-level checks for the class priority request queue top
// uses cpq_pkg; bound to class_priority_request_queue_top
`default_nettype none

module cpq_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        req_op,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [1:0]  rsp_status,
   input wire [15:0] rsp_out_tag,
   input wire        rsp_out_is_image,
   input wire [4:0]  rsp_occupancy
);

   // a refused or empty transaction carries no entry
   a_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == cpq_pkg::ST_FULL || rsp_status == cpq_pkg::ST_EMPTY)
      |-> (rsp_out_tag == '0) && !rsp_out_is_image)
      else $error("data on refused or empty result");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cpq_pkg::ST_EMPTY |-> rsp_occupancy == '0)
      else $error("empty status with nonzero occupancy");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_occupancy) <= 32'(cpq_pkg::DEPTH))
      else $error("occupancy above depth");

   // an accepted enqueue never reports empty
   a_enq_status: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == cpq_pkg::OP_ENQ
      |=> rsp_valid && (rsp_status == cpq_pkg::ST_OK || rsp_status == cpq_pkg::ST_FULL))
      else $error("bad status after enqueue");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_tag))
      else $error("stalled result changed");

endmodule

bind class_priority_request_queue_top cpq_checker u_cpq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_op           (req_op),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_out_tag      (rsp_out_tag),
   .rsp_out_is_image (rsp_out_is_image),
   .rsp_occupancy    (rsp_occupancy)
);

`default_nettype wire

FILE: dv/cpq_queue_checker.sv
// class priority request queue checker: watches the req_, rsp_ and csr_ channels,
// predicts each response and compares it field by field
// depends on cpq_pkg for widths, status, op, mode and register codes
`timescale 1ns / 1ps

module cpq_queue_checker
   import cpq_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_stall,
   input  wire                req_op,
   input  wire [15:0]         req_tag,
   input  wire                req_is_image,
   input  wire                rsp_valid,
   input  wire                rsp_stall,
   input  wire [1:0]          rsp_status,
   input  wire [15:0]         rsp_out_tag,
   input  wire                rsp_out_is_image,
   input  wire [4:0]          rsp_occupancy,
   input  wire                csr_valid,
   input  wire                csr_ready,
   input  wire [CSR_AW-1:0]   csr_index,
   input  wire [CSR_DW-1:0]   csr_wdata,
   output int                 error_count,
   output int                 pending_count,
   output int                 txn_count,
   output int                 refused_count,
   output int                 empty_count,
   output int                 reorder_count
);

   typedef struct packed {
      logic [1:0]       status;
      logic [15:0]      tag;
      logic             is_image;
      logic [OCC_W-1:0] occupancy;
   } result_type;

   entry_type         held_entries [DEPTH];
   int                held_count;
   logic [MODE_W-1:0] sched_mode;
   logic [CAP_W-1:0]  capacity;
   result_type        pending_responses [$];
   result_type        want_res;
   result_type        got_res;
   int                errors;
   int                n_txn;
   int                n_refused;
   int                n_empty;
   int                n_reorder;

   initial begin
      errors        = 0;
      n_txn         = 0;
      n_refused     = 0;
      n_empty       = 0;
      n_reorder     = 0;
      error_count   = 0;
      pending_count = 0;
   end

   task automatic predict_queue_op(input logic op, input logic [15:0] new_tag,
                                   input logic new_image, output result_type res);
      int pick;
      int limit;
      res        = '0;
      res.status = ST_OK;
      limit      = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
      if (op == OP_ENQ) begin
         if (held_count >= limit) begin
            res.status = ST_FULL;
            n_refused++;
         end else begin
            held_entries[held_count].tag      = new_tag;
            held_entries[held_count].is_image = new_image;
            held_count++;
         end
      end else if (held_count == 0) begin
         res.status = ST_EMPTY;
         n_empty++;
      end else begin
         pick = 0;
         if (sched_mode == MODE_IMAGE || sched_mode == MODE_TEXT) begin
            for (int i = held_count - 1; i >= 0; i--) begin
               if (held_entries[i].is_image == (sched_mode == MODE_IMAGE)) pick = i;
            end
         end
         if (pick > 0) n_reorder++;
         res.tag      = held_entries[pick].tag;
         res.is_image = held_entries[pick].is_image;
         for (int i = pick; i < held_count - 1; i++) held_entries[i] = held_entries[i + 1];
         held_count--;
      end
      res.occupancy = held_count[OCC_W-1:0];
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         sched_mode = MODE_FIFO;
         capacity   = CAP_RESET;
         pending_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_res = '{rsp_status, rsp_out_tag, rsp_out_is_image, rsp_occupancy};
            if (pending_responses.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %0h", $time, got_res);
               errors++;
            end else begin
               want_res = pending_responses.pop_front();
               check_field("status", want_res.status, got_res.status);
               check_field("out_tag", want_res.tag, got_res.tag);
               check_field("out_is_image", want_res.is_image, got_res.is_image);
               check_field("occupancy", want_res.occupancy, got_res.occupancy);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_SCHED_MODE) sched_mode = csr_wdata[MODE_W-1:0];
            else if (csr_index == REG_CAPACITY) capacity = csr_wdata[CAP_W-1:0];
         end
         if (req_valid && !req_stall) begin
            predict_queue_op(req_op, req_tag, req_is_image, want_res);
            pending_responses.push_back(want_res);
            n_txn++;
         end
      end
      pending_count <= pending_responses.size();
      error_count   <= errors;
      txn_count     <= n_txn;
      refused_count <= n_refused;
      empty_count   <= n_empty;
      reorder_count <= n_reorder;
   end

endmodule

FILE: dv/tb_class_priority_request_queue_top.sv
// testbench top for the class priority request queue: clock, reset, stimulus and verdict
// instantiates class_priority_request_queue_top and cpq_queue_checker, uses cpq_pkg
`timescale 1ns / 1ps

module tb_class_priority_request_queue_top;
   import cpq_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1100;

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_op       = OP_ENQ;
   logic [15:0]       req_tag      = '0;
   logic              req_is_image = 1'b0;
   logic              rsp_stall    = 1'b0;
   logic              csr_valid    = 1'b0;
   logic [CSR_AW-1:0] csr_index    = '0;
   logic [CSR_DW-1:0] csr_wdata    = '0;
   wire               req_stall;
   wire               rsp_valid;
   wire  [1:0]        rsp_status;
   wire  [15:0]       rsp_out_tag;
   wire               rsp_out_is_image;
   wire  [4:0]        rsp_occupancy;
   wire               csr_ready;

   int error_count;
   int pending_count;
   int txn_count;
   int refused_count;
   int empty_count;
   int reorder_count;

   int cycle_count = 0;
   int stall_left  = 0;
   int stall_style = 0;
   int burst_left  = 0;
   int rand_count;
   int phase_count;
   int phase_items;
   int enq_pct;
   int img_pct;
   int cap_choice;
   logic [CAP_W-1:0]  cap_value;
   logic [MODE_W-1:0] mode_value;
   logic              op_value;
   logic [15:0]       tag_value;

   class_priority_request_queue_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_tag          (req_tag),
      .req_is_image     (req_is_image),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_is_image (rsp_out_is_image),
      .rsp_occupancy    (rsp_occupancy),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   cpq_queue_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_tag          (req_tag),
      .req_is_image     (req_is_image),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_is_image (rsp_out_is_image),
      .rsp_occupancy    (rsp_occupancy),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .txn_count        (txn_count),
      .refused_count    (refused_count),
      .empty_count      (empty_count),
      .reorder_count    (reorder_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver stall pattern: free-running, light and heavy stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= $urandom_range(0, 2);
         stall_left  <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   task automatic send_request(input logic op, input logic [15:0] tag, input logic img);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_op       <= op;
      req_tag      <= tag;
      req_is_image <= img;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_tag();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, empty, fill to full, refusal, each mode
      send_request(OP_DEQ, 16'($urandom), 1'($urandom));
      for (int i = 0; i < 16; i++) begin
         tag_value = (i == 0) ? 16'h0000 : (i == 15) ? 16'hFFFF : 16'($urandom);
         send_request(OP_ENQ, tag_value, (i % 3) == 1);
      end
      send_request(OP_ENQ, 16'hFFFF, 1'b1);
      send_request(OP_DEQ, 16'hFFFF, 1'b1);
      send_request(OP_DEQ, 16'h0000, 1'b0);
      wait_idle();
      write_csr(REG_SCHED_MODE, {6'd0, MODE_IMAGE});
      send_request(OP_DEQ, 16'($urandom), 1'b0);
      send_request(OP_DEQ, 16'($urandom), 1'b0);
      wait_idle();
      write_csr(REG_SCHED_MODE, {6'd0, MODE_TEXT});
      send_request(OP_DEQ, 16'($urandom), 1'b1);
      send_request(OP_DEQ, 16'($urandom), 1'b1);
      wait_idle();
      // capacity lowered below the held count
      write_csr(REG_CAPACITY, 8'd1);
      send_request(OP_ENQ, 16'h5A5A, 1'b1);

      // random phases, each with its own settings and traffic mix
      rand_count  = 0;
      phase_count = 0;
      while (rand_count < RANDOM_ITEMS) begin
         wait_idle();
         cap_choice = (phase_count < 7) ? phase_count : $urandom_range(0, 6);
         case (cap_choice)
            0: cap_value = 5'd0;
            1: cap_value = 5'd31;
            2: cap_value = 5'd1;
            3: cap_value = 5'd16;
            4: cap_value = 5'd2;
            5: cap_value = 5'($urandom_range(17, 30));
            default: cap_value = 5'($urandom_range(3, 15));
         endcase
         mode_value = (phase_count < 4) ? MODE_W'(phase_count) : MODE_W'($urandom_range(0, 3));
         write_csr(REG_SCHED_MODE, {6'($urandom), mode_value});
         write_csr(REG_CAPACITY, {3'($urandom), cap_value});
         if ($urandom_range(0, 2) == 0) write_csr(CSR_AW'($urandom_range(2, 255)), 8'($urandom));
         case ($urandom_range(0, 2))
            0: enq_pct = 30;
            1: enq_pct = 50;
            default: enq_pct = 70;
         endcase
         case ($urandom_range(0, 2))
            0: img_pct = 10;
            1: img_pct = 50;
            default: img_pct = 90;
         endcase
         phase_items = $urandom_range(30, 90);
         for (int i = 0; i < phase_items; i++) begin
            op_value = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
            send_request(op_value, pick_tag(), $urandom_range(0, 99) < img_pct);
            rand_count++;
         end
         phase_count++;
      end

      wait_idle();
      repeat (4) @(posedge clock);
      $display("covered %0d transactions over %0d random phases: %0d refused enqueues,",
               txn_count, phase_count, refused_count);
      $display("%0d dequeues on empty, %0d dequeues taken out of arrival order",
               empty_count, reorder_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
